@@ rtl/fpfa_pkg.sv @@
`timescale 1ns / 1ps

package fpfa_pkg;

  // Stream field widths
  localparam int MODE_W     = 2;
  localparam int PIDX_W     = 4;
  localparam int AMT_W      = 16;
  localparam int OUT_IDX_W  = 4;
  localparam int OUT_SIZE_W = 16;
  localparam int S_DATA_W   = 24;
  localparam int M_DATA_W   = 24;

  // Configuration port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam int POLICY_W   = 2;
  localparam int PIU_W      = 5;

  // Register index, taken from paddr[2]
  localparam logic REG_FIT_POLICY   = 1'b0;
  localparam logic REG_PARTS_IN_USE = 1'b1;

  // Item modes
  localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REQ    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REPORT = 2'd2;

  // Fit policies (unused code behaves as first fit)
  localparam logic [POLICY_W-1:0] POL_FIRST = 2'd0;
  localparam logic [POLICY_W-1:0] POL_BEST  = 2'd1;
  localparam logic [POLICY_W-1:0] POL_WORST = 2'd2;

  // Report listing limit
  localparam int RES_W = 5;
  localparam logic [RES_W-1:0] MAX_RESULTS = 5'd16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH,
    ST_EMIT
  } state_t;

  // Table access strobes from the sequencer
  typedef struct packed {
    logic wr_en;
    logic rd_en;
    logic free_clr;
  } tbl_op_t;

  // Fit unit verdict
  typedef struct packed {
    logic fits;
    logic take;
  } fit_res_t;

endpackage

@@ rtl/fpfa_cfg.sv @@
`timescale 1ns / 1ps

module fpfa_cfg #(
  parameter int MAX_PARTITIONS = 16,
  localparam int CNT_W = $clog2(MAX_PARTITIONS + 1)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [fpfa_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [fpfa_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [fpfa_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready,
  output logic [fpfa_pkg::POLICY_W-1:0]     policy,
  output logic [CNT_W-1:0]                  active_n
);

  localparam int CW = (CNT_W > fpfa_pkg::PIU_W) ? CNT_W : fpfa_pkg::PIU_W;

  logic                         wr;
  logic [fpfa_pkg::PIU_W-1:0]   parts_in_use;
  logic [CW-1:0]                piu_w;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      policy       <= fpfa_pkg::POL_FIRST;
      parts_in_use <= '0;
    end else if (wr) begin
      case (paddr[2])
        fpfa_pkg::REG_FIT_POLICY:   policy       <= pwdata[fpfa_pkg::POLICY_W-1:0];
        fpfa_pkg::REG_PARTS_IN_USE: parts_in_use <= pwdata[fpfa_pkg::PIU_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (paddr[2])
      fpfa_pkg::REG_FIT_POLICY:   prdata = fpfa_pkg::APB_DATA_W'(policy);
      fpfa_pkg::REG_PARTS_IN_USE: prdata = fpfa_pkg::APB_DATA_W'(parts_in_use);
      default:                    prdata = '0;
    endcase
  end

  // Entry count clamped to the table depth
  assign piu_w    = CW'(parts_in_use);
  assign active_n = (piu_w > CW'(MAX_PARTITIONS)) ? CNT_W'(MAX_PARTITIONS) : CNT_W'(piu_w);

endmodule

@@ rtl/fpfa_table.sv @@
`timescale 1ns / 1ps

module fpfa_table #(
  parameter int MAX_PARTITIONS = 16,
  parameter int SIZE_BITS      = 16,
  localparam int IDX_W = $clog2(MAX_PARTITIONS)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  fpfa_pkg::tbl_op_t       op,
  input  logic [IDX_W-1:0]        waddr,
  input  logic [SIZE_BITS-1:0]    wdata,
  input  logic [IDX_W-1:0]        raddr,
  input  logic [IDX_W-1:0]        clr_addr,
  output logic [SIZE_BITS-1:0]    rdata,
  output logic                    free_rd
);

  logic [SIZE_BITS-1:0]      size_mem [MAX_PARTITIONS];
  logic [MAX_PARTITIONS-1:0] free_q;

  // Size store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (op.wr_en) begin
      size_mem[waddr] <= wdata;
    end
    if (op.rd_en) begin
      rdata <= size_mem[raddr];
    end
  end

  // Free flags: set on load, cleared on grant
  always_ff @(posedge clk) begin
    if (rst) begin
      free_q <= '0;
    end else begin
      if (op.wr_en) begin
        free_q[waddr] <= 1'b1;
      end
      if (op.free_clr) begin
        free_q[clr_addr] <= 1'b0;
      end
    end
  end

  assign free_rd = free_q[raddr];

endmodule

@@ rtl/fpfa_fit.sv @@
`timescale 1ns / 1ps

module fpfa_fit #(
  parameter int SIZE_BITS = 16
) (
  input  logic [fpfa_pkg::POLICY_W-1:0] policy,
  input  logic [SIZE_BITS-1:0]          req,
  input  logic [SIZE_BITS-1:0]          cand,
  input  logic                          best_vld,
  input  logic [SIZE_BITS-1:0]          best_size,
  output fpfa_pkg::fit_res_t            res
);

  // Shared comparator: fit test plus policy-specific improvement test.
  // Strict compares keep the lowest index on ties.
  always_comb begin
    res.fits = (cand >= req);
    case (policy)
      fpfa_pkg::POL_WORST: res.take = !best_vld || (cand > best_size);
      fpfa_pkg::POL_BEST:  res.take = res.fits && (!best_vld || (cand < best_size));
      default:             res.take = res.fits && !best_vld;
    endcase
  end

endmodule

@@ rtl/fpfa_seq.sv @@
`timescale 1ns / 1ps

module fpfa_seq #(
  parameter int MAX_PARTITIONS = 16,
  parameter int SIZE_BITS      = 16,
  localparam int IDX_W = $clog2(MAX_PARTITIONS),
  localparam int CNT_W = $clog2(MAX_PARTITIONS + 1)
) (
  input  logic                              clk,
  input  logic                              rst,
  // input stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [fpfa_pkg::S_DATA_W-1:0]     s_tdata,
  input  logic [fpfa_pkg::MODE_W-1:0]       s_tuser,
  // result stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [fpfa_pkg::M_DATA_W-1:0]     m_tdata,
  output logic                              m_tlast,
  // configuration
  input  logic [fpfa_pkg::POLICY_W-1:0]     policy,
  input  logic [CNT_W-1:0]                  active_n,
  // table
  output fpfa_pkg::tbl_op_t                 tbl_op,
  output logic [IDX_W-1:0]                  waddr,
  output logic [SIZE_BITS-1:0]              wdata,
  output logic [IDX_W-1:0]                  raddr,
  output logic [IDX_W-1:0]                  clr_addr,
  input  logic [SIZE_BITS-1:0]              rdata,
  input  logic                              free_rd
);

  localparam int PW = (IDX_W > fpfa_pkg::PIDX_W) ? IDX_W : fpfa_pkg::PIDX_W;
  localparam int PAD_W = fpfa_pkg::M_DATA_W - 1 - fpfa_pkg::OUT_IDX_W - fpfa_pkg::OUT_SIZE_W;

  fpfa_pkg::state_t state, state_next;

  logic [fpfa_pkg::MODE_W-1:0]   mode_in;
  logic [fpfa_pkg::PIDX_W-1:0]   pidx_in;
  logic [fpfa_pkg::AMT_W-1:0]    amt_in;
  logic [PW-1:0]                 pidx_w;
  logic [SIZE_BITS-1:0]          amt_cut;
  logic                          in_range;
  logic                          accept;

  logic [fpfa_pkg::MODE_W-1:0]   mode_r;
  logic [SIZE_BITS-1:0]          req;
  logic [CNT_W-1:0]              cnt;
  logic                          eval_vld;
  logic [IDX_W-1:0]              eval_idx;
  logic                          eval_free;
  logic                          pick_vld;
  logic [IDX_W-1:0]              pick_idx;
  logic [SIZE_BITS-1:0]          pick_size;
  logic [fpfa_pkg::RES_W-1:0]    rep_k;

  logic                          res_found;
  logic [fpfa_pkg::OUT_IDX_W-1:0]  res_idx;
  logic [fpfa_pkg::OUT_SIZE_W-1:0] res_size;

  logic                          out_found;
  logic [fpfa_pkg::OUT_IDX_W-1:0]  out_idx;
  logic [fpfa_pkg::OUT_SIZE_W-1:0] out_size;

  logic                          out_load;
  logic                          ld_found;
  logic [fpfa_pkg::OUT_IDX_W-1:0]  ld_idx;
  logic [fpfa_pkg::OUT_SIZE_W-1:0] ld_size;
  logic                          ld_last;

  logic                          out_busy;
  logic                          report_hit;
  logic                          stall;
  logic                          adv;
  logic                          issue;
  logic                          scan_end;
  logic                          pick_upd;
  logic                          grant;
  logic                          fin_ok;
  logic [SIZE_BITS-1:0]          cand;
  fpfa_pkg::fit_res_t            fit;

  // Input unpacking
  assign mode_in  = s_tuser;
  assign pidx_in  = s_tdata[fpfa_pkg::PIDX_W-1:0];
  assign amt_in   = s_tdata[fpfa_pkg::PIDX_W +: fpfa_pkg::AMT_W];
  assign pidx_w   = PW'(pidx_in);
  assign amt_cut  = SIZE_BITS'(amt_in);
  assign in_range = (32'(pidx_in) < 32'(MAX_PARTITIONS));
  assign accept   = s_tvalid && s_tready;

  // Shared compare unit: scans table data, then rechecks the worst-fit pick
  assign cand = (state == fpfa_pkg::ST_FINISH) ? pick_size : rdata;

  fpfa_fit #(
    .SIZE_BITS (SIZE_BITS)
  ) u_fit (
    .policy    (policy),
    .req       (req),
    .cand      (cand),
    .best_vld  (pick_vld),
    .best_size (pick_size),
    .res       (fit)
  );

  // Scan control
  assign out_busy   = m_tvalid && !m_tready;
  assign report_hit = eval_vld && (mode_r == fpfa_pkg::MODE_REPORT) && eval_free &&
                      (rep_k < fpfa_pkg::MAX_RESULTS);
  assign stall      = (state == fpfa_pkg::ST_SCAN) && report_hit && pick_vld && out_busy;
  assign adv        = (state == fpfa_pkg::ST_SCAN) && !stall;
  assign issue      = adv && (cnt != active_n);
  assign scan_end   = (state == fpfa_pkg::ST_SCAN) && (cnt == active_n) && !eval_vld;
  assign pick_upd   = adv && (report_hit ||
                      (eval_vld && (mode_r == fpfa_pkg::MODE_REQ) && eval_free && fit.take));
  assign grant      = pick_vld && ((policy != fpfa_pkg::POL_WORST) || fit.fits);
  assign fin_ok     = (mode_r == fpfa_pkg::MODE_REQ) ? grant : pick_vld;

  // Table addressing
  assign waddr    = pidx_w[IDX_W-1:0];
  assign wdata    = amt_cut;
  assign raddr    = cnt[IDX_W-1:0];
  assign clr_addr = pick_idx;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      fpfa_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          case (mode_in)
            fpfa_pkg::MODE_REQ,
            fpfa_pkg::MODE_REPORT: state_next = fpfa_pkg::ST_SCAN;
            default:               state_next = fpfa_pkg::ST_EMIT;
          endcase
        end
      end
      fpfa_pkg::ST_SCAN: begin
        if (scan_end) begin
          state_next = fpfa_pkg::ST_FINISH;
        end
      end
      fpfa_pkg::ST_FINISH: state_next = fpfa_pkg::ST_EMIT;
      fpfa_pkg::ST_EMIT: begin
        if (!out_busy) begin
          state_next = fpfa_pkg::ST_IDLE;
        end
      end
      default: state_next = fpfa_pkg::ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    s_tready        = 1'b0;
    tbl_op          = '0;
    out_load        = 1'b0;
    ld_found        = res_found;
    ld_idx          = res_idx;
    ld_size         = res_size;
    ld_last         = 1'b1;
    case (state)
      fpfa_pkg::ST_IDLE: begin
        s_tready     = 1'b1;
        tbl_op.wr_en = s_tvalid && (mode_in == fpfa_pkg::MODE_LOAD) && in_range;
      end
      fpfa_pkg::ST_SCAN: begin
        tbl_op.rd_en = issue;
        // a new free entry pushes the held one out, not yet marked last
        if (adv && report_hit && pick_vld) begin
          out_load = 1'b1;
          ld_found = 1'b1;
          ld_idx   = fpfa_pkg::OUT_IDX_W'(pick_idx);
          ld_size  = fpfa_pkg::OUT_SIZE_W'(pick_size);
          ld_last  = 1'b0;
        end
      end
      fpfa_pkg::ST_FINISH: begin
        tbl_op.free_clr = (mode_r == fpfa_pkg::MODE_REQ) && grant;
      end
      fpfa_pkg::ST_EMIT: begin
        out_load = !out_busy;
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= fpfa_pkg::ST_IDLE;
      m_tvalid <= 1'b0;
      cnt      <= '0;
      eval_vld <= 1'b0;
      pick_vld <= 1'b0;
      rep_k    <= '0;
    end else begin
      state <= state_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (accept) begin
        cnt      <= '0;
        eval_vld <= 1'b0;
        pick_vld <= 1'b0;
        rep_k    <= '0;
      end else if (adv) begin
        eval_vld <= issue;
        if (issue) begin
          cnt <= CNT_W'(cnt + 1'b1);
        end
        if (pick_upd) begin
          pick_vld <= 1'b1;
          if (mode_r == fpfa_pkg::MODE_REPORT) begin
            rep_k <= fpfa_pkg::RES_W'(rep_k + 1'b1);
          end
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= mode_in;
      req    <= amt_cut;
      if ((mode_in == fpfa_pkg::MODE_LOAD) && in_range) begin
        res_found <= 1'b1;
        res_idx   <= pidx_in;
        res_size  <= fpfa_pkg::OUT_SIZE_W'(amt_cut);
      end else if (mode_in == fpfa_pkg::MODE_LOAD) begin
        res_found <= 1'b0;
        res_idx   <= pidx_in;
        res_size  <= '0;
      end else begin
        res_found <= 1'b0;
        res_idx   <= '0;
        res_size  <= '0;
      end
    end
    if (issue) begin
      eval_idx  <= cnt[IDX_W-1:0];
      eval_free <= free_rd;
    end
    if (pick_upd) begin
      pick_idx  <= eval_idx;
      pick_size <= rdata;
    end
    if (state == fpfa_pkg::ST_FINISH) begin
      res_found <= fin_ok;
      res_idx   <= fin_ok ? fpfa_pkg::OUT_IDX_W'(pick_idx) : '0;
      res_size  <= fin_ok ? fpfa_pkg::OUT_SIZE_W'(pick_size) : '0;
    end
    if (out_load) begin
      out_found <= ld_found;
      out_idx   <= ld_idx;
      out_size  <= ld_size;
      m_tlast   <= ld_last;
    end
  end

  assign m_tdata = {{PAD_W{1'b0}}, out_size, out_idx, out_found};

endmodule

@@ rtl/fixed_partition_fit_allocator.sv @@
`timescale 1ns / 1ps

// Fixed-partition allocator: a table of MAX_PARTITIONS partition sizes with
// free flags (none free after reset). Each input transaction is a load
// (write a size, mark it free), a request (grant one free partition under
// the first, best or worst fit policy and mark it used) or a report (list the
// free partitions in index order, at most sixteen, tlast on the final one).
// Every item gives at least one result. A single comparator walks the
// table one entry per cycle while no report result stalls on the output; a
// request or report scans the active entries, then settles its pick and
// offers its last result, and a load or an unused mode offers its result
// directly. The next item is taken only once that last result is in the
// output register. s_tready is high only between items, while the last
// result may still wait in the output register.
module fixed_partition_fit_allocator #(
  parameter int MAX_PARTITIONS = 16,
  parameter int SIZE_BITS      = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  // input items
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [fpfa_pkg::S_DATA_W-1:0]     s_tdata,   // partition_index[3:0], amount[19:4]
  input  logic [fpfa_pkg::MODE_W-1:0]       s_tuser,   // mode[1:0]
  // results
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [fpfa_pkg::M_DATA_W-1:0]     m_tdata,   // found[0], chosen_index[4:1],
                                                       // chosen_size[20:5]
  output logic                              m_tlast,
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [fpfa_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [fpfa_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [fpfa_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);

  localparam int IDX_W = $clog2(MAX_PARTITIONS);
  localparam int CNT_W = $clog2(MAX_PARTITIONS + 1);

  logic [fpfa_pkg::POLICY_W-1:0] policy;
  logic [CNT_W-1:0]              active_n;
  fpfa_pkg::tbl_op_t             tbl_op;
  logic [IDX_W-1:0]              waddr;
  logic [SIZE_BITS-1:0]          wdata;
  logic [IDX_W-1:0]              raddr;
  logic [IDX_W-1:0]              clr_addr;
  logic [SIZE_BITS-1:0]          rdata;
  logic                          free_rd;

  fpfa_cfg #(
    .MAX_PARTITIONS (MAX_PARTITIONS)
  ) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .policy   (policy),
    .active_n (active_n)
  );

  fpfa_table #(
    .MAX_PARTITIONS (MAX_PARTITIONS),
    .SIZE_BITS      (SIZE_BITS)
  ) u_table (
    .clk      (clk),
    .rst      (rst),
    .op       (tbl_op),
    .waddr    (waddr),
    .wdata    (wdata),
    .raddr    (raddr),
    .clr_addr (clr_addr),
    .rdata    (rdata),
    .free_rd  (free_rd)
  );

  fpfa_seq #(
    .MAX_PARTITIONS (MAX_PARTITIONS),
    .SIZE_BITS      (SIZE_BITS)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .policy   (policy),
    .active_n (active_n),
    .tbl_op   (tbl_op),
    .waddr    (waddr),
    .wdata    (wdata),
    .raddr    (raddr),
    .clr_addr (clr_addr),
    .rdata    (rdata),
    .free_rd  (free_rd)
  );

endmodule

@@ rtl/fpfa_checker.sv @@
`timescale 1ns / 1ps

module fpfa_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [fpfa_pkg::M_DATA_W-1:0] m_tdata,
  input logic                          m_tlast
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed while stalled");

  // One item at a time: input closes after each accepted transaction
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted on consecutive cycles");

  // A miss carries no size
  a_miss_size: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata[20:5] == 16'd0)
    else $error("miss result with non-zero size");

  // A miss is always the only, hence last, result of its item
  a_miss_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tlast)
    else $error("miss result without tlast");

endmodule

bind fixed_partition_fit_allocator fpfa_checker u_fpfa_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
